[design/tlvsfr_pkg.sv]
// ----------------------------------------------------------------------------
// tlvsfr_pkg
// shared types, constants and the crc byte update for the tlv frame receiver
// ----------------------------------------------------------------------------
package tlvsfr_pkg;

  // payload store size in bytes
  localparam int MaxPayload = 64;
  localparam int AddrW      = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam int IdxW       = $clog2(MaxPayload + 1);

  localparam int CfgIdxW = 2;

  localparam logic [7:0]  SyncFirstRst  = 8'hA5;
  localparam logic [7:0]  SyncSecondRst = 8'h5A;
  localparam logic [15:0] CrcPoly       = 16'h1021;
  localparam logic [15:0] CrcInit       = 16'hFFFF;
  localparam logic [15:0] CrcMsb        = 16'h8000;

  localparam logic [CfgIdxW-1:0] RegSyncFirst  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegSyncSecond = CfgIdxW'(1);

  typedef enum logic [1:0] {
    STAT_GOOD    = 2'd0,
    STAT_CRC_ERR = 2'd1,
    STAT_LEN_ERR = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SRC_LEN_ERR = 2'd0,
    SRC_CRC_ERR = 2'd1,
    SRC_EMPTY   = 2'd2,
    SRC_PAYLOAD = 2'd3
  } out_src_e;

  // controller to datapath
  typedef struct packed {
    logic     crc_init;
    logic     crc_upd;
    logic     tag_load;
    logic     len_load;
    logic     crch_load;
    logic     idx_clear;
    logic     idx_inc;
    logic     ram_we;
    logic     ram_re;
    logic [1:0] drop_add;
    logic     good_inc;
    logic     crcerr_inc;
    logic     out_load;
    out_src_e out_src;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sync1_hit;
    logic sync2_hit;
    logic len_big;
    logic byte_zero;
    logic len_hold_zero;
    logic data_done;
    logic crc_ok;
    logic rd_last;
    logic out_free;
  } dp_status_t;

  // crc-16/ccitt-false, one byte, msb first
  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((r & CrcMsb) != 16'h0000) begin
        r = {r[14:0], 1'b0} ^ CrcPoly;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

[design/tlvsfr_ram.sv]
// ----------------------------------------------------------------------------
// tlvsfr_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module tlvsfr_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  waddr_i,
  input  logic [Width-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  raddr_i,
  output logic [Width-1:0]                              rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/tlvsfr_ctrl.sv]
// ----------------------------------------------------------------------------
// tlvsfr_ctrl
// frame phase state machine, issues datapath commands per byte
// ----------------------------------------------------------------------------
module tlvsfr_ctrl import tlvsfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    ST_HUNT  = 9'b000000001,
    ST_SYNC2 = 9'b000000010,
    ST_TAG   = 9'b000000100,
    ST_LEN   = 9'b000001000,
    ST_DATA  = 9'b000010000,
    ST_CRCH  = 9'b000100000,
    ST_CRCL  = 9'b001000000,
    ST_RD    = 9'b010000000,
    ST_LOAD  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   fire;

  assign fire = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.out_src = SRC_EMPTY;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_HUNT: begin
        in_ready_o = 1'b1;
        if (fire) begin
          if (status_i.sync1_hit) begin
            state_d = ST_SYNC2;
          end else begin
            cmd_o.drop_add = 2'd1;
          end
        end
      end
      ST_SYNC2: begin
        in_ready_o = 1'b1;
        if (fire) begin
          priority if (status_i.sync2_hit) begin
            cmd_o.crc_init = 1'b1;
            state_d        = ST_TAG;
          end else if (status_i.sync1_hit) begin
            cmd_o.drop_add = 2'd1;
          end else begin
            cmd_o.drop_add = 2'd2;
            state_d        = ST_HUNT;
          end
        end
      end
      ST_TAG: begin
        in_ready_o = 1'b1;
        if (fire) begin
          cmd_o.tag_load = 1'b1;
          cmd_o.crc_upd  = 1'b1;
          state_d        = ST_LEN;
        end
      end
      ST_LEN: begin
        // may emit a length error, so needs a free output slot
        in_ready_o = status_i.out_free;
        if (fire) begin
          cmd_o.len_load  = 1'b1;
          cmd_o.idx_clear = 1'b1;
          cmd_o.crc_upd   = 1'b1;
          priority if (status_i.len_big) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_src  = SRC_LEN_ERR;
            state_d        = ST_HUNT;
          end else if (status_i.byte_zero) begin
            state_d = ST_CRCH;
          end else begin
            state_d = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        in_ready_o = 1'b1;
        if (fire) begin
          cmd_o.ram_we  = 1'b1;
          cmd_o.crc_upd = 1'b1;
          cmd_o.idx_inc = 1'b1;
          if (status_i.data_done) begin
            state_d = ST_CRCH;
          end
        end
      end
      ST_CRCH: begin
        in_ready_o = 1'b1;
        if (fire) begin
          cmd_o.crch_load = 1'b1;
          state_d         = ST_CRCL;
        end
      end
      ST_CRCL: begin
        in_ready_o = status_i.out_free;
        if (fire) begin
          priority if (!status_i.crc_ok) begin
            cmd_o.crcerr_inc = 1'b1;
            cmd_o.out_load   = 1'b1;
            cmd_o.out_src    = SRC_CRC_ERR;
            state_d          = ST_HUNT;
          end else if (status_i.len_hold_zero) begin
            cmd_o.good_inc = 1'b1;
            cmd_o.out_load = 1'b1;
            cmd_o.out_src  = SRC_EMPTY;
            state_d        = ST_HUNT;
          end else begin
            cmd_o.good_inc  = 1'b1;
            cmd_o.idx_clear = 1'b1;
            state_d         = ST_RD;
          end
        end
      end
      ST_RD: begin
        cmd_o.ram_re = 1'b1;
        state_d      = ST_LOAD;
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_src  = SRC_PAYLOAD;
          cmd_o.idx_inc  = 1'b1;
          state_d        = status_i.rd_last ? ST_HUNT : ST_RD;
        end
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

  // no input taken while the store is read out
  a_no_input_in_readout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !(state_q == ST_RD || state_q == ST_LOAD))
    else $error("input ready during payload read-out");

  // every read issue is followed by its load step
  a_rd_then_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |=> (state_q == ST_LOAD))
    else $error("read issue not followed by load");

endmodule

[design/tlvsfr_dp.sv]
// ----------------------------------------------------------------------------
// tlvsfr_dp
// datapath: sync registers, crc, frame holds, counters, store, output register
// ----------------------------------------------------------------------------
module tlvsfr_dp import tlvsfr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  input  logic [7:0]         rx_byte_i,
  input  ctrl_cmd_t          cmd_i,
  output dp_status_t         status_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [1:0]         status_field_o,
  output logic [7:0]         frame_tag_o,
  output logic [7:0]         frame_length_o,
  output logic               has_payload_o,
  output logic [7:0]         payload_byte_o,
  output logic [5:0]         payload_index_o,
  output logic               last_o,
  output logic [31:0]        good_frames_o,
  output logic [31:0]        crc_failures_o,
  output logic [31:0]        dropped_bytes_o
);

  logic [7:0]      sync_first_q, sync_second_q;
  logic [7:0]      tag_q, tag_d;
  logic [7:0]      len_q, len_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0]     crc_q, crc_d;
  logic [7:0]      crch_q;
  logic [31:0]     good_q, good_d;
  logic [31:0]     crcerr_q, crcerr_d;
  logic [31:0]     drop_q, drop_d;
  logic [7:0]      ram_rdata;
  logic [7:0]      idx_next;

  // output register
  logic        ovalid_q;
  status_e     ostat_q;
  logic [7:0]  otag_q, olen_q, obyte_q;
  logic        ohas_q, olast_q;
  logic [5:0]  oidx_q;
  logic [31:0] ogood_q, ocrc_q, odrop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SyncFirstRst;
      sync_second_q <= SyncSecondRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegSyncFirst) begin
        sync_first_q <= cfg_data_i;
      end
      if (cfg_index_i == RegSyncSecond) begin
        sync_second_q <= cfg_data_i;
      end
    end
  end

  assign idx_next = 8'(idx_q) + 8'd1;

  always_comb begin
    tag_d    = cmd_i.tag_load ? rx_byte_i : tag_q;
    len_d    = cmd_i.len_load ? rx_byte_i : len_q;
    idx_d    = idx_q;
    if (cmd_i.idx_clear) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + IdxW'(1);
    end
    crc_d    = crc_q;
    if (cmd_i.crc_init) begin
      crc_d = CrcInit;
    end else if (cmd_i.crc_upd) begin
      crc_d = crc_step(crc_q, rx_byte_i);
    end
    good_d   = good_q + 32'(cmd_i.good_inc);
    crcerr_d = crcerr_q + 32'(cmd_i.crcerr_inc);
    drop_d   = drop_q + 32'(cmd_i.drop_add);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q    <= '0;
      len_q    <= '0;
      idx_q    <= '0;
      crc_q    <= CrcInit;
      crch_q   <= '0;
      good_q   <= '0;
      crcerr_q <= '0;
      drop_q   <= '0;
    end else begin
      tag_q    <= tag_d;
      len_q    <= len_d;
      idx_q    <= idx_d;
      crc_q    <= crc_d;
      good_q   <= good_d;
      crcerr_q <= crcerr_d;
      drop_q   <= drop_d;
      if (cmd_i.crch_load) begin
        crch_q <= rx_byte_i;
      end
    end
  end

  tlvsfr_ram #(
    .Width (8),
    .Depth (MaxPayload)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (idx_q[AddrW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.ram_re),
    .raddr_i (idx_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign status_o.sync1_hit     = (rx_byte_i == sync_first_q);
  assign status_o.sync2_hit     = (rx_byte_i == sync_second_q);
  assign status_o.len_big       = (rx_byte_i > 8'(MaxPayload));
  assign status_o.byte_zero     = (rx_byte_i == 8'd0);
  assign status_o.len_hold_zero = (len_q == 8'd0);
  assign status_o.data_done     = (idx_next >= len_q);
  assign status_o.crc_ok        = ({crch_q, rx_byte_i} == crc_q);
  assign status_o.rd_last       = (idx_next == len_q);
  assign status_o.out_free      = !ovalid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      otag_q  <= tag_d;
      olen_q  <= len_d;
      ogood_q <= good_d;
      ocrc_q  <= crcerr_d;
      odrop_q <= drop_d;
      ohas_q  <= 1'b0;
      obyte_q <= 8'd0;
      oidx_q  <= 6'd0;
      olast_q <= 1'b1;
      unique case (cmd_i.out_src)
        SRC_LEN_ERR: ostat_q <= STAT_LEN_ERR;
        SRC_CRC_ERR: ostat_q <= STAT_CRC_ERR;
        SRC_EMPTY:   ostat_q <= STAT_GOOD;
        SRC_PAYLOAD: begin
          ostat_q <= STAT_GOOD;
          ohas_q  <= 1'b1;
          obyte_q <= ram_rdata;
          oidx_q  <= 6'(idx_q);
          olast_q <= status_o.rd_last;
        end
        default: ostat_q <= STAT_GOOD;
      endcase
    end
  end

  assign out_valid_o     = ovalid_q;
  assign status_field_o  = ostat_q;
  assign frame_tag_o     = otag_q;
  assign frame_length_o  = olen_q;
  assign has_payload_o   = ohas_q;
  assign payload_byte_o  = obyte_q;
  assign payload_index_o = oidx_q;
  assign last_o          = olast_q;
  assign good_frames_o   = ogood_q;
  assign crc_failures_o  = ocrc_q;
  assign dropped_bytes_o = odrop_q;

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!ovalid_q || out_ready_i))
    else $error("output register overwritten");

  // payload writes stay inside the store
  a_store_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ram_we |-> (idx_q < IdxW'(MaxPayload)))
    else $error("payload store overrun");

endmodule

[design/tlv_stream_frame_receiver.sv]
// ----------------------------------------------------------------------------
// tlv_stream_frame_receiver
// sync hunt, tlv frame parse with crc-16/ccitt-false check, payload read-out
// ----------------------------------------------------------------------------
//
// channel  direction  handshake                 payload
// -------  ---------  ------------------------  ---------------------------------
// cfg      in         cfg_valid_i/cfg_ready_o   cfg_index_i, cfg_data_i
// in       in         in_valid_i/in_ready_o     rx_byte_i
// out      out        out_valid_o/out_ready_i   status_o .. dropped_bytes_o
//
// header, payload and crc bytes are taken one beat per cycle
// the length byte and the low crc byte wait for a free output register
// a good frame with payload is read out of the store beat by beat, each
//   beat a read issue, then a load; input held off until the last beat loads
// reset is asynchronous, active low; the store needs no clearing
// a stalled output holds its beat; config writes are always taken
//
module tlv_stream_frame_receiver import tlvsfr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // config write
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i,
  // received bytes
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  // results
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [7:0]         frame_tag_o,
  output logic [7:0]         frame_length_o,
  output logic               has_payload_o,
  output logic [7:0]         payload_byte_o,
  output logic [5:0]         payload_index_o,
  output logic               last_o,
  output logic [31:0]        good_frames_o,
  output logic [31:0]        crc_failures_o,
  output logic [31:0]        dropped_bytes_o
);

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;

  // registers are plain flops, a write lands every beat
  assign cfg_ready_o = 1'b1;

  // phase sequencing and read-out control
  tlvsfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  // crc, holds, counters, payload store and the output register
  tlvsfr_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .rx_byte_i       (rx_byte_i),
    .cmd_i           (cmd),
    .status_o        (dp_status),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .status_field_o  (status_o),
    .frame_tag_o     (frame_tag_o),
    .frame_length_o  (frame_length_o),
    .has_payload_o   (has_payload_o),
    .payload_byte_o  (payload_byte_o),
    .payload_index_o (payload_index_o),
    .last_o          (last_o),
    .good_frames_o   (good_frames_o),
    .crc_failures_o  (crc_failures_o),
    .dropped_bytes_o (dropped_bytes_o)
  );

endmodule
